// File: rtl/core/jfss_pkg.sv
// jfss_pkg: shared types and constants for the jpeg frame size scanner
// no dependencies; used by the parser, the top level and the bench
`timescale 1ns / 1ps

package jfss_pkg;

  localparam logic [7:0] MarkLead = 8'hFF;
  localparam logic [7:0] MarkSoi  = 8'hD8;
  localparam logic [7:0] MarkSof0 = 8'hC0;
  localparam logic [15:0] SofMinLen = 16'd5;
  localparam logic [15:0] SegMinLen = 16'd2;
  localparam logic [7:0] SofKinds = 8'd3;

  typedef enum logic [2:0] {
    StFound    = 3'd0,
    StBadSig   = 3'd1,
    StSync     = 3'd2,
    StTrunc    = 3'd3,
    StShortSof = 3'd4,
    StBadLen   = 3'd5
  } status_e;

  typedef struct packed {
    logic        hit;
    status_e     status;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [1:0]  frame_kind;
  } result_t;

endpackage

// File: rtl/core/jfss_byte_if.sv
// jfss_byte_if: valid/ready channel carrying file bytes into the scanner
// no dependencies
`timescale 1ns / 1ps

interface jfss_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

// File: rtl/core/jfss_result_if.sv
// jfss_result_if: valid/ready channel carrying one scan result per file
// no dependencies
`timescale 1ns / 1ps

interface jfss_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [1:0]  frame_kind;

  modport source (output valid, output status, output image_width, output image_height,
                  output frame_kind, input ready);
  modport sink (input valid, input status, input image_width, input image_height,
                input frame_kind, output ready);
endinterface

// File: rtl/core/jfss_parser.sv
// jfss_parser: marker segment walker, one byte per step, result formed combinationally
// depends on jfss_pkg
`timescale 1ns / 1ps

module jfss_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_file_i,
  output jfss_pkg::result_t result_o
);

  typedef enum logic [3:0] {
    PhSig0, PhSig1, PhSig2, PhMarker, PhLenHi, PhLenLo, PhSkip, PhSync,
    PhSofLenHi, PhSofLenLo, PhPrec, PhHHi, PhHLo, PhWHi, PhWLo, PhDone
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] skip_q, skip_d;
  logic [7:0]  hi_q, hi_d;
  logic [15:0] height_q, height_d;
  logic [1:0]  kind_q, kind_d;

  logic [15:0] word;
  logic [7:0]  kind_off;

  assign word     = {hi_q, data_byte_i};
  assign kind_off = data_byte_i - jfss_pkg::MarkSof0;

  always_comb begin
    phase_d  = phase_q;
    skip_d   = skip_q;
    hi_d     = hi_q;
    height_d = height_q;
    kind_d   = kind_q;
    result_o = '0;

    unique case (phase_q)
      PhSig0: begin
        if (data_byte_i != jfss_pkg::MarkLead) begin
          result_o.hit    = 1'b1;
          result_o.status = jfss_pkg::StBadSig;
          phase_d         = PhDone;
        end else begin
          phase_d = PhSig1;
        end
      end
      PhSig1: begin
        if (data_byte_i != jfss_pkg::MarkSoi) begin
          result_o.hit    = 1'b1;
          result_o.status = jfss_pkg::StBadSig;
          phase_d         = PhDone;
        end else begin
          phase_d = PhSig2;
        end
      end
      PhSig2: begin
        if (data_byte_i != jfss_pkg::MarkLead) begin
          result_o.hit    = 1'b1;
          result_o.status = jfss_pkg::StBadSig;
          phase_d         = PhDone;
        end else begin
          phase_d = PhMarker;
        end
      end
      PhMarker: begin
        if (data_byte_i >= jfss_pkg::MarkSof0 && kind_off < jfss_pkg::SofKinds) begin
          kind_d  = kind_off[1:0];
          phase_d = PhSofLenHi;
        end else begin
          phase_d = PhLenHi;
        end
      end
      PhLenHi: begin
        hi_d    = data_byte_i;
        phase_d = PhLenLo;
      end
      PhLenLo: begin
        if (word < jfss_pkg::SegMinLen) begin
          result_o.hit    = 1'b1;
          result_o.status = jfss_pkg::StBadLen;
          phase_d         = PhDone;
        end else begin
          skip_d  = word - jfss_pkg::SegMinLen;
          phase_d = (word == jfss_pkg::SegMinLen) ? PhSync : PhSkip;
        end
      end
      PhSkip: begin
        skip_d = skip_q - 16'd1;
        if (skip_q == 16'd1) begin
          phase_d = PhSync;
        end
      end
      PhSync: begin
        if (data_byte_i != jfss_pkg::MarkLead) begin
          result_o.hit    = 1'b1;
          result_o.status = jfss_pkg::StSync;
          phase_d         = PhDone;
        end else begin
          phase_d = PhMarker;
        end
      end
      PhSofLenHi: begin
        hi_d    = data_byte_i;
        phase_d = PhSofLenLo;
      end
      PhSofLenLo: begin
        skip_d  = word;
        phase_d = PhPrec;
      end
      PhPrec: begin
        if (skip_q < jfss_pkg::SofMinLen) begin
          result_o.hit    = 1'b1;
          result_o.status = jfss_pkg::StShortSof;
          phase_d         = PhDone;
        end else begin
          phase_d = PhHHi;
        end
      end
      PhHHi: begin
        hi_d    = data_byte_i;
        phase_d = PhHLo;
      end
      PhHLo: begin
        height_d = word;
        phase_d  = PhWHi;
      end
      PhWHi: begin
        hi_d    = data_byte_i;
        phase_d = PhWLo;
      end
      PhWLo: begin
        result_o.hit          = 1'b1;
        result_o.status       = jfss_pkg::StFound;
        result_o.image_width  = word;
        result_o.image_height = height_q;
        result_o.frame_kind   = kind_q;
        phase_d               = PhDone;
      end
      PhDone: begin
        phase_d = PhDone;
      end
      default: begin
        phase_d = PhSig0;
      end
    endcase

    // last byte of the file: report a bad signature or truncation if nothing was given, then restart
    if (end_of_file_i) begin
      if (!result_o.hit && phase_q != PhDone) begin
        result_o.hit    = 1'b1;
        result_o.status = (phase_d == PhSig0 || phase_d == PhSig1 || phase_d == PhSig2)
                          ? jfss_pkg::StBadSig : jfss_pkg::StTrunc;
      end
      phase_d  = PhSig0;
      skip_d   = '0;
      hi_d     = '0;
      height_d = '0;
      kind_d   = '0;
    end

    if (!step_i) begin
      result_o.hit = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhSig0;
      skip_q   <= '0;
      hi_q     <= '0;
      height_q <= '0;
      kind_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      skip_q   <= skip_d;
      hi_q     <= hi_d;
      height_q <= height_d;
      kind_q   <= kind_d;
    end
  end

endmodule

// File: rtl/core/jpeg_frame_size_scanner_unit.sv
// jpeg_frame_size_scanner_unit: scans a jpeg byte stream for the first sof segment
// the deciding byte passes the input register and the parser step into the result register
// throughput: one byte per cycle, set by the single parser step between input and result register
// an untaken result stalls the input once the input register holds a byte
// reset clears the parser state and the valid flags of the input and result registers
// depends on jfss_pkg, jfss_byte_if, jfss_result_if, jfss_parser
`timescale 1ns / 1ps

module jpeg_frame_size_scanner_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  jfss_byte_if.sink     in_i,
  jfss_result_if.source out_o
);

  logic              in_valid_q;
  logic [7:0]        byte_q;
  logic              eof_q;
  logic              advance;
  logic              out_valid_q;
  jfss_pkg::result_t res;
  jfss_pkg::result_t out_q;

  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      byte_q <= in_i.data_byte;
      eof_q  <= in_i.end_of_file;
    end
  end

  jfss_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .data_byte_i   (byte_q),
    .end_of_file_i (eof_q),
    .result_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res.hit;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.hit) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_q.status;
  assign out_o.image_width  = out_q.image_width;
  assign out_o.image_height = out_q.image_height;
  assign out_o.frame_kind   = out_q.frame_kind;

`ifndef SYNTHESIS
  a_no_result_without_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.hit |-> advance)
    else $error("parser result without a step");

  a_error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != jfss_pkg::StFound) |->
      (out_q.image_width == 16'd0 && out_q.image_height == 16'd0 && out_q.frame_kind == 2'd0))
    else $error("error result carries frame data");

  a_stall_only_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (in_valid_q && out_valid_q && !out_o.ready))
    else $error("input stalled without a blocked result");

  a_result_kept_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_q)))
    else $error("blocked result lost or changed");
`endif

endmodule

// File: sim/tb_jpeg_frame_size_scanner_unit.sv
// tb_jpeg_frame_size_scanner_unit: self-checking bench for the jpeg frame size scanner
// a directed table, then random files, checked against an in-bench byte-level parser
// depends on jfss_pkg, jfss_byte_if, jfss_result_if and jpeg_frame_size_scanner_unit
`timescale 1ns / 1ps

module tb_jpeg_frame_size_scanner_unit;

  localparam int HoldCycles = 300;
  localparam int StallLimit = 2000;
  localparam int DrainCycles = 8;

  typedef enum logic [3:0] {
    PhSig0, PhSig1, PhSig2, PhMarker, PhLenHi, PhLenLo, PhSkip, PhSync,
    PhSofLenHi, PhSofLenLo, PhPrec, PhHeightHi, PhHeightLo, PhWidthHi, PhWidthLo, PhDone
  } scan_phase_e;

  typedef struct packed {
    jfss_pkg::status_e status;
    logic [15:0]       width;
    logic [15:0]       height;
    logic [1:0]        kind;
  } frame_info_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        pinned;
    frame_info_t want;
  } byte_row_t;

  localparam frame_info_t NoFrame = '{jfss_pkg::StFound, 16'h0000, 16'h0000, 2'd0};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  jfss_byte_if   byte_bus ();
  jfss_result_if result_bus ();

  jpeg_frame_size_scanner_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_bus),
    .out_o  (result_bus)
  );

  always #4 clk_i = ~clk_i;

  // parser state mirrored in the bench
  scan_phase_e phase;
  logic [15:0] bytes_left;
  logic [7:0]  upper_byte;
  logic [15:0] height_q;
  logic [1:0]  kind_q;
  logic        reported;

  frame_info_t pending_frames[$];
  logic [7:0]  file_bytes[$];
  byte_row_t   directed_rows[27];

  logic        pin_row;
  frame_info_t pin_frame;
  bit          idling;
  bit          hold_req;
  int          error_count;
  int          parsed_bytes;
  int          files_seen;
  int          results_seen;
  int          status_seen[6];
  int          idle_cycles;

  function automatic void clear_scan_state();
    phase      = PhSig0;
    bytes_left = 16'h0000;
    upper_byte = 8'h00;
    height_q   = 16'h0000;
    kind_q     = 2'd0;
    reported   = 1'b0;
  endfunction

  function automatic bit scan_byte(input logic [7:0] b, input logic eof,
                                   output frame_info_t res);
    bit          hit;
    logic [15:0] word;
    hit  = 1'b0;
    res  = NoFrame;
    word = {upper_byte, b};
    if (!reported) begin
      case (phase)
        PhSig0: begin
          if (b != jfss_pkg::MarkLead) begin
            hit = 1'b1;
            res.status = jfss_pkg::StBadSig;
          end else phase = PhSig1;
        end
        PhSig1: begin
          if (b != jfss_pkg::MarkSoi) begin
            hit = 1'b1;
            res.status = jfss_pkg::StBadSig;
          end else phase = PhSig2;
        end
        PhSig2: begin
          if (b != jfss_pkg::MarkLead) begin
            hit = 1'b1;
            res.status = jfss_pkg::StBadSig;
          end else phase = PhMarker;
        end
        PhMarker: begin
          if (b >= jfss_pkg::MarkSof0 && b < jfss_pkg::MarkSof0 + jfss_pkg::SofKinds) begin
            kind_q = b[1:0];
            phase  = PhSofLenHi;
          end else phase = PhLenHi;
        end
        PhLenHi: begin
          upper_byte = b;
          phase      = PhLenLo;
        end
        PhLenLo: begin
          if (word < jfss_pkg::SegMinLen) begin
            hit = 1'b1;
            res.status = jfss_pkg::StBadLen;
          end else begin
            bytes_left = word - jfss_pkg::SegMinLen;
            phase      = (bytes_left == 16'h0000) ? PhSync : PhSkip;
          end
        end
        PhSkip: begin
          bytes_left = bytes_left - 16'd1;
          if (bytes_left == 16'h0000) phase = PhSync;
        end
        PhSync: begin
          if (b != jfss_pkg::MarkLead) begin
            hit = 1'b1;
            res.status = jfss_pkg::StSync;
          end else phase = PhMarker;
        end
        PhSofLenHi: begin
          upper_byte = b;
          phase      = PhSofLenLo;
        end
        PhSofLenLo: begin
          bytes_left = word;
          phase      = PhPrec;
        end
        PhPrec: begin
          if (bytes_left < jfss_pkg::SofMinLen) begin
            hit = 1'b1;
            res.status = jfss_pkg::StShortSof;
          end else phase = PhHeightHi;
        end
        PhHeightHi: begin
          upper_byte = b;
          phase      = PhHeightLo;
        end
        PhHeightLo: begin
          height_q = word;
          phase    = PhWidthHi;
        end
        PhWidthHi: begin
          upper_byte = b;
          phase      = PhWidthLo;
        end
        PhWidthLo: begin
          hit = 1'b1;
          res = '{jfss_pkg::StFound, word, height_q, kind_q};
        end
        default: begin
        end
      endcase
    end
    if (hit) begin
      reported = 1'b1;
      phase    = PhDone;
    end
    if (eof) begin
      if (!reported) begin
        hit = 1'b1;
        res.status = (phase <= PhSig2) ? jfss_pkg::StBadSig : jfss_pkg::StTrunc;
      end
      clear_scan_state();
    end
    return hit;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("mismatch: %s", msg);
  endtask

  // transfer monitor: predict on byte transfers, compare on result transfers
  always @(posedge clk_i) begin : transfer_monitor
    frame_info_t res;
    frame_info_t got;
    frame_info_t want;
    bit          hit;
    if (rst_ni) begin
      if (byte_bus.valid && byte_bus.ready) begin
        parsed_bytes++;
        if (byte_bus.end_of_file) files_seen++;
        hit = scan_byte(byte_bus.data_byte, byte_bus.end_of_file, res);
        if (pin_row) pending_frames.push_back(pin_frame);
        else if (hit) pending_frames.push_back(res);
      end
      if (result_bus.valid && result_bus.ready) begin
        got = '{jfss_pkg::status_e'(result_bus.status), result_bus.image_width,
                result_bus.image_height, result_bus.frame_kind};
        results_seen++;
        if (result_bus.status <= 3'd5) status_seen[result_bus.status]++;
        if (pending_frames.size() == 0) begin
          flag_error($sformatf("unexpected result status %0d width %h height %h kind %0d",
                               got.status, got.width, got.height, got.kind));
        end else begin
          want = pending_frames.pop_front();
          if (got.status !== want.status || got.width !== want.width ||
              got.height !== want.height || got.kind !== want.kind) begin
            flag_error($sformatf({"expected status %0d width %h height %h kind %0d, ",
                                  "got status %0d width %h height %h kind %0d"},
                                 want.status, want.width, want.height, want.kind,
                                 got.status, got.width, got.height, got.kind));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (byte_bus.valid && byte_bus.ready) ||
        (result_bus.valid && result_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result receiver
  initial begin : result_sink
    result_bus.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        result_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
        result_bus.ready <= 1'b1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        result_bus.ready <= 1'b1;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  task automatic offer_byte(input logic [7:0] b, input logic last, input logic pinned,
                            input frame_info_t want);
    byte_bus.valid       <= 1'b1;
    byte_bus.data_byte   <= b;
    byte_bus.end_of_file <= last;
    pin_row              <= pinned;
    pin_frame            <= want;
    do @(posedge clk_i); while (!byte_bus.ready);
    if (idling && $urandom_range(0, 4) == 0) begin
      byte_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++) begin
      offer_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b0, NoFrame);
    end
  endtask

  task automatic build_clean_file();
    logic [7:0]  mark;
    logic [15:0] seg_len;
    logic [15:0] sof_len;
    file_bytes.delete();
    file_bytes.push_back(jfss_pkg::MarkLead);
    file_bytes.push_back(jfss_pkg::MarkSoi);
    file_bytes.push_back(jfss_pkg::MarkLead);
    repeat ($urandom_range(0, 3)) begin
      do mark = 8'($urandom_range(0, 255));
      while (mark >= jfss_pkg::MarkSof0 && mark < jfss_pkg::MarkSof0 + jfss_pkg::SofKinds);
      seg_len = ($urandom_range(0, 9) == 0) ? jfss_pkg::SegMinLen
                                            : 16'($urandom_range(3, 10));
      file_bytes.push_back(mark);
      file_bytes.push_back(seg_len[15:8]);
      file_bytes.push_back(seg_len[7:0]);
      repeat (seg_len - jfss_pkg::SegMinLen) file_bytes.push_back(8'($urandom_range(0, 255)));
      file_bytes.push_back(jfss_pkg::MarkLead);
    end
    file_bytes.push_back(jfss_pkg::MarkSof0 + 8'($urandom_range(0, 2)));
    sof_len = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 4))
                                          : 16'($urandom_range(5, 65535));
    file_bytes.push_back(sof_len[15:8]);
    file_bytes.push_back(sof_len[7:0]);
    // precision, height, width
    repeat (5) file_bytes.push_back(8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic build_file();
    int pick;
    int cut;
    pick = $urandom_range(0, 99);
    if (pick < 90) begin
      build_clean_file();
      if (pick >= 80) begin
        file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (pick >= 70) begin
        cut = $urandom_range(1, file_bytes.size());
        while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end
    end else begin
      file_bytes.delete();
      if (pick < 95) begin
        // long segment, file ends inside it
        file_bytes.push_back(jfss_pkg::MarkLead);
        file_bytes.push_back(jfss_pkg::MarkSoi);
        file_bytes.push_back(jfss_pkg::MarkLead);
        file_bytes.push_back(8'hE1);
        file_bytes.push_back(8'($urandom_range(128, 255)));
        file_bytes.push_back(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 6)) file_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 8)) file_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic drain_results();
    byte_bus.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    byte_bus.valid       <= 1'b0;
    byte_bus.data_byte   <= 8'h00;
    byte_bus.end_of_file <= 1'b0;
    pin_row              <= 1'b0;
    pin_frame            <= NoFrame;
    clear_scan_state();
    directed_rows = '{
      // wrong first signature byte
      '{8'h00, 1'b1, 1'b1, '{jfss_pkg::StBadSig, 16'h0000, 16'h0000, 2'd0}},
      // file ends inside the signature
      '{8'hFF, 1'b1, 1'b1, '{jfss_pkg::StBadSig, 16'h0000, 16'h0000, 2'd0}},
      // fill byte taken as a marker, empty segment, then no marker lead
      '{8'hFF, 1'b0, 1'b0, NoFrame},
      '{8'hD8, 1'b0, 1'b0, NoFrame},
      '{8'hFF, 1'b0, 1'b0, NoFrame},
      '{8'hFF, 1'b0, 1'b0, NoFrame},
      '{8'h00, 1'b0, 1'b0, NoFrame},
      '{8'h02, 1'b0, 1'b0, NoFrame},
      '{8'h00, 1'b1, 1'b1, '{jfss_pkg::StSync, 16'h0000, 16'h0000, 2'd0}},
      // segment length below two
      '{8'hFF, 1'b0, 1'b0, NoFrame},
      '{8'hD8, 1'b0, 1'b0, NoFrame},
      '{8'hFF, 1'b0, 1'b0, NoFrame},
      '{8'h01, 1'b0, 1'b0, NoFrame},
      '{8'h00, 1'b0, 1'b0, NoFrame},
      '{8'h01, 1'b1, 1'b1, '{jfss_pkg::StBadLen, 16'h0000, 16'h0000, 2'd0}},
      // sof2 at minimum length, largest frame, one byte after the result
      '{8'hFF, 1'b0, 1'b0, NoFrame},
      '{8'hD8, 1'b0, 1'b0, NoFrame},
      '{8'hFF, 1'b0, 1'b0, NoFrame},
      '{8'hC2, 1'b0, 1'b0, NoFrame},
      '{8'h00, 1'b0, 1'b0, NoFrame},
      '{8'h05, 1'b0, 1'b0, NoFrame},
      '{8'h08, 1'b0, 1'b0, NoFrame},
      '{8'hFF, 1'b0, 1'b0, NoFrame},
      '{8'hFF, 1'b0, 1'b0, NoFrame},
      '{8'hFF, 1'b0, 1'b0, NoFrame},
      '{8'hFF, 1'b0, 1'b1, '{jfss_pkg::StFound, 16'hFFFF, 16'hFFFF, 2'd2}},
      '{8'h5A, 1'b1, 1'b0, NoFrame}
    };
    idling = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      offer_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].pinned,
                 directed_rows[i].want);
    end

    while (parsed_bytes < 400) begin
      build_file();
      send_file();
    end

    // sender pause until every result is back, then a long receiver hold-off
    drain_results();
    idling   = 1'b0;
    hold_req = 1'b1;
    while (hold_req) begin
      build_file();
      send_file();
    end

    while (parsed_bytes < 950) begin
      idling = ($urandom_range(0, 3) != 0);
      build_file();
      send_file();
    end

    idling = 1'b0;
    while (parsed_bytes < 1200) begin
      build_file();
      send_file();
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_frames.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_frames.size()));
    end
    $display("scanned %0d bytes over %0d files, %0d results compared, %0d mismatches",
             parsed_bytes, files_seen, results_seen, error_count);
    $display("found %0d, bad signature %0d, sync %0d, truncated %0d, short sof %0d, bad length %0d",
             status_seen[jfss_pkg::StFound], status_seen[jfss_pkg::StBadSig],
             status_seen[jfss_pkg::StSync], status_seen[jfss_pkg::StTrunc],
             status_seen[jfss_pkg::StShortSof], status_seen[jfss_pkg::StBadLen]);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/jfss_pkg.sv
rtl/core/jfss_byte_if.sv
rtl/core/jfss_result_if.sv
rtl/core/jfss_parser.sv
rtl/core/jpeg_frame_size_scanner_unit.sv
sim/tb_jpeg_frame_size_scanner_unit.sv
